// ===== rtl/tbm_pkg.sv =====
// Shared types and constants for the timestamp timebase mapper.
package tbm_pkg;

  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
  localparam logic [63:0] WHOLE_MAX  = 64'd18446744073;
  localparam logic [63:0] MAX_S64    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [5:0]  DIV_LAST   = 6'd63;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_SCALE = 3'd1;
  localparam logic [2:0] ST_SCALE_CHG = 3'd2;
  localparam logic [2:0] ST_BACKWARD  = 3'd3;
  localparam logic [2:0] ST_DELTA_OVF = 3'd4;
  localparam logic [2:0] ST_SUM_OVF   = 3'd5;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [30:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quot;
    logic [30:0] rem;
  } div_rsp_t;

endpackage

// ===== rtl/tbm_if.sv =====
// Valid/ready channel interfaces for input and result items.
interface tbm_in_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] tick_value;
  logic signed [31:0] timescale;

  modport source (output valid, output tick_value, output timescale, input ready);
  modport sink (input valid, input tick_value, input timescale, output ready);
endinterface

interface tbm_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] mapped_time;
  logic        [2:0]  status;

  modport source (output valid, output mapped_time, output status, input ready);
  modport sink (input valid, input mapped_time, input status, output ready);
endinterface

// ===== rtl/tbm_div.sv =====
// Iterative restoring divider, 64-bit dividend by 31-bit divisor, one bit a cycle.
module tbm_div (
  input  logic              clk,
  input  logic              rst_n,
  input  tbm_pkg::div_req_t req,
  output tbm_pkg::div_rsp_t rsp
);
  import tbm_pkg::*;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [30:0] rem_r, rem_nxt;
  logic [30:0] dvs_r, dvs_nxt;
  logic [31:0] trial;
  logic [31:0] diff;

  assign trial = {rem_r, quo_r[63]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (!diff[31]) begin
        rem_nxt = diff[30:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial[30:0];
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == DIV_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== rtl/timestamp_timebase_mapper_top.sv =====
// Top level of the timestamp timebase mapper: sequencer, multiplier and stream state.
//
//  channel | direction | signals
//  --------+-----------+-------------------------------------------------
//  in_ch   | sink      | valid, ready, tick_value[63:0], timescale[31:0]
//  out_ch  | source    | valid, ready, mapped_time[63:0], status[2:0]
//  cfg     | write     | cfg_we, cfg_wdata[63:0]
//
//  An item that needs the conversion makes two passes through the shared 64-step
//  divider plus seven sequencer steps. Anchor and input-rejected items bypass the divider.
//  One item at a time; in_ch.ready is high only while the sequencer is idle.
//  The result holds on out_ch until taken. rst_n is synchronous and clears the anchor.
module timestamp_timebase_mapper_top (
  input  logic         clk,
  input  logic         rst_n,
  tbm_in_if.sink       in_ch,
  tbm_out_if.source    out_ch,
  input  logic         cfg_we,
  input  logic [63:0]  cfg_wdata
);
  import tbm_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DIV1  = 9'b000000010,
    S_CHK   = 9'b000000100,
    S_MUL_R = 9'b000001000,
    S_MUL_W = 9'b000010000,
    S_MUL_H = 9'b000100000,
    S_DIV2  = 9'b001000000,
    S_SUM   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t      state_r, state_nxt;
  logic        anchored_r, anchored_nxt;
  logic [63:0] pa_r, pa_nxt;
  logic [63:0] anc_ticks_r, anc_ticks_nxt;
  logic [30:0] anc_scale_r, anc_scale_nxt;
  logic [63:0] last_r, last_nxt;
  logic [63:0] v_r, v_nxt;
  logic [63:0] whole_r, whole_nxt;
  logic [30:0] rem_r, rem_nxt;
  logic [61:0] prod_r, prod_nxt;
  logic [63:0] wn_r, wn_nxt;
  logic [63:0] cap_r, cap_nxt;
  logic [64:0] dns_r, dns_nxt;
  logic [63:0] mapped_r, mapped_nxt;
  logic [2:0]  status_r, status_nxt;
  logic [31:0] mul_a;
  logic [63:0] delta;
  logic        accept;
  logic        ts_bad;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  tbm_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign accept = in_ch.valid && in_ch.ready;
  assign ts_bad = in_ch.timescale[31] || (in_ch.timescale == 32'sd0);
  assign delta  = in_ch.tick_value - anc_ticks_r;

  always_comb begin
    case (state_r)
      S_CHK:   mul_a = {1'b0, rem_r};
      S_MUL_R: mul_a = whole_r[31:0];
      default: mul_a = {29'd0, whole_r[34:32]};
    endcase
  end

  assign prod_nxt = mul_a * NS_PER_SEC;

  always_comb begin
    state_nxt        = state_r;
    anchored_nxt     = anchored_r;
    pa_nxt           = pa_r;
    anc_ticks_nxt    = anc_ticks_r;
    anc_scale_nxt    = anc_scale_r;
    last_nxt         = last_r;
    v_nxt            = v_r;
    whole_nxt        = whole_r;
    rem_nxt          = rem_r;
    wn_nxt           = wn_r;
    cap_nxt          = cap_r;
    dns_nxt          = dns_r;
    mapped_nxt       = mapped_r;
    status_nxt       = status_r;
    div_req.start    = 1'b0;
    div_req.dividend = (state_r == S_IDLE) ? delta : {2'b00, prod_r};
    div_req.divisor  = anc_scale_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          mapped_nxt = '0;
          state_nxt  = S_OUT;
          if (ts_bad) begin
            status_nxt = ST_BAD_SCALE;
          end else if (!anchored_r) begin
            anchored_nxt  = 1'b1;
            anc_ticks_nxt = in_ch.tick_value;
            anc_scale_nxt = in_ch.timescale[30:0];
            last_nxt      = in_ch.tick_value;
            mapped_nxt    = pa_r;
            status_nxt    = ST_OK;
          end else if (in_ch.timescale[30:0] != anc_scale_r) begin
            status_nxt = ST_SCALE_CHG;
          end else if (in_ch.tick_value < $signed(last_r)) begin
            status_nxt = ST_BACKWARD;
          end else begin
            div_req.start = 1'b1;
            v_nxt         = in_ch.tick_value;
            state_nxt     = S_DIV1;
          end
        end
      end
      S_DIV1: begin
        if (div_rsp.done) begin
          whole_nxt = div_rsp.quot;
          rem_nxt   = div_rsp.rem;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (whole_r > WHOLE_MAX) begin
          mapped_nxt = '0;
          status_nxt = ST_DELTA_OVF;
          state_nxt  = S_OUT;
        end else begin
          state_nxt = S_MUL_R;
        end
      end
      S_MUL_R: begin
        div_req.start = 1'b1;
        state_nxt     = S_MUL_W;
      end
      S_MUL_W: begin
        wn_nxt    = {2'b00, prod_r};
        state_nxt = S_MUL_H;
      end
      S_MUL_H: begin
        wn_nxt    = wn_r + {prod_r[31:0], 32'd0};
        cap_nxt   = MAX_S64 - pa_r;
        state_nxt = S_DIV2;
      end
      S_DIV2: begin
        if (div_rsp.done) begin
          dns_nxt   = {1'b0, wn_r} + {1'b0, div_rsp.quot};
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        mapped_nxt = '0;
        state_nxt  = S_OUT;
        if (dns_r[64]) begin
          status_nxt = ST_DELTA_OVF;
        end else if (dns_r[63:0] > cap_r) begin
          status_nxt = ST_SUM_OVF;
        end else begin
          mapped_nxt = pa_r + dns_r[63:0];
          status_nxt = ST_OK;
          last_nxt   = v_r;
        end
      end
      S_OUT: begin
        if (out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      pa_nxt       = cfg_wdata;
      anchored_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      anchored_r <= 1'b0;
      pa_r       <= '0;
    end else begin
      state_r    <= state_nxt;
      anchored_r <= anchored_nxt;
      pa_r       <= pa_nxt;
    end
    anc_ticks_r <= anc_ticks_nxt;
    anc_scale_r <= anc_scale_nxt;
    last_r      <= last_nxt;
    v_r         <= v_nxt;
    whole_r     <= whole_nxt;
    rem_r       <= rem_nxt;
    prod_r      <= prod_nxt;
    wn_r        <= wn_nxt;
    cap_r       <= cap_nxt;
    dns_r       <= dns_nxt;
    mapped_r    <= mapped_nxt;
    status_r    <= status_nxt;
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = (state_r == S_OUT);
  assign out_ch.mapped_time = mapped_r;
  assign out_ch.status      = status_r;

`ifndef NO_ASSERTIONS
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV1 || state_r == S_DIV2))
    else $error("divider result arrived outside a wait step");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != ST_OK) |-> out_ch.mapped_time == 64'd0)
    else $error("error item carries a non-zero time");

  a_cfg_unanchor: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !anchored_r)
    else $error("anchor survived a register write");
`endif

endmodule

// ===== sim/timestamp_timebase_mapper_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the tick-to-nanosecond mapper: streams, errors, overflows, stalls.
module timestamp_timebase_mapper_top_tb;
  import tbm_pkg::*;

  localparam logic signed [63:0] MAX_TICKS = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] MIN_TICKS = 64'sh8000_0000_0000_0000;
  localparam logic signed [31:0] MAX_SCALE = 32'sh7FFF_FFFF;
  localparam logic [63:0] NS_SEC = 64'd1_000_000_000;
  localparam logic [63:0] WHOLE_SEC_LIMIT = 64'hFFFF_FFFF_FFFF_FFFF / NS_SEC;
  localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [63:0] mapped_ns;
    logic [2:0]  status;
  } ns_result_t;

  class timebase_scoreboard;
    logic [63:0]        project_anchor;
    bit                 anchored;
    logic signed [63:0] anchor_ticks;
    logic signed [63:0] last_ticks;
    logic [30:0]        anchor_scale;
    ns_result_t         expected_ns_q[$];
    int                 failures;
    int                 reported;

    function new();
      project_anchor = '0;
      anchored = 1'b0;
      failures = 0;
      reported = 0;
    endfunction

    function void set_anchor(logic [63:0] value);
      project_anchor = value;
      anchored = 1'b0;
    endfunction

    function void note_input(logic signed [63:0] tick, logic signed [31:0] scale);
      ns_result_t  res;
      logic [63:0] divisor, delta, whole, rem, whole_ns, frac_ns, delta_ns;
      res.mapped_ns = '0;
      res.status = ST_OK;
      divisor = {33'd0, scale[30:0]};
      if (scale <= 32'sd0) begin
        res.status = ST_BAD_SCALE;
      end else if (!anchored) begin
        anchored = 1'b1;
        anchor_ticks = tick;
        anchor_scale = scale[30:0];
        last_ticks = tick;
        res.mapped_ns = project_anchor;
      end else if (scale[30:0] != anchor_scale) begin
        res.status = ST_SCALE_CHG;
      end else if (tick < last_ticks) begin
        res.status = ST_BACKWARD;
      end else begin
        delta = tick - anchor_ticks;
        whole = delta / divisor;
        rem = delta % divisor;
        if (whole > WHOLE_SEC_LIMIT) begin
          res.status = ST_DELTA_OVF;
        end else begin
          whole_ns = whole * NS_SEC;
          frac_ns = (rem * NS_SEC) / divisor;
          if (frac_ns > ~whole_ns) begin
            res.status = ST_DELTA_OVF;
          end else begin
            delta_ns = whole_ns + frac_ns;
            if (delta_ns > POS_LIMIT - project_anchor) begin
              res.status = ST_SUM_OVF;
            end else begin
              res.mapped_ns = project_anchor + delta_ns;
              last_ticks = tick;
            end
          end
        end
      end
      expected_ns_q.push_back(res);
    endfunction

    function void check_result(logic [63:0] mapped_ns, logic [2:0] status);
      ns_result_t exp_res;
      if (expected_ns_q.size() == 0) begin
        failures++;
        reported++;
        if (reported <= 10)
          $display("unexpected result: ns=%0d status=%0d", $signed(mapped_ns), status);
      end else begin
        exp_res = expected_ns_q.pop_front();
        if (exp_res.mapped_ns !== mapped_ns || exp_res.status !== status) begin
          failures++;
          reported++;
          if (reported <= 10)
            $display("mismatch: expected ns=%0d status=%0d, got ns=%0d status=%0d",
                     $signed(exp_res.mapped_ns), exp_res.status, $signed(mapped_ns), status);
        end
      end
    endfunction

    function int pending();
      return expected_ns_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [63:0] cfg_wdata;
  bit          quiet = 1'b0;
  bit          hold_off_req = 1'b0;

  timebase_scoreboard sb;

  tbm_in_if  in_ch();
  tbm_out_if out_ch();

  timestamp_timebase_mapper_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int idle_cycles();
    return quiet ? 0 : $urandom_range(0, 5);
  endfunction

  task automatic send_item(input logic signed [63:0] tick, input logic signed [31:0] scale);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.tick_value <= tick;
    in_ch.timescale <= scale;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(tick, scale);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_anchor(input logic [63:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_anchor(value);
  endtask

  initial begin : result_taker
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      stall = idle_cycles();
      if (hold_off_req) begin
        stall = 400;
        hold_off_req = 1'b0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      sb.check_result(out_ch.mapped_time, out_ch.status);
      @(negedge clk);
    end
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    logic signed [63:0] anchor_val, start, base, tick;
    logic signed [31:0] scale, ts;
    logic [63:0]        step, wide;
    int                 r;
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.tick_value = '0;
    in_ch.timescale = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(64'sd0, 32'sd0);
    send_item(MIN_TICKS, -32'sd1);
    send_item(MAX_TICKS, 32'sh8000_0000);
    send_item(64'sd1000, 32'sd90000);
    send_item(64'sd1000, 32'sd90000);
    send_item(64'sd91000, 32'sd90000);
    send_item(64'sd200000, 32'sd48000);
    send_item(64'sd999, 32'sd90000);
    send_item(64'sd136000, 32'sd90000);
    send_item(64'sd1, 32'sd0);
    write_anchor(MIN_TICKS);
    send_item(MIN_TICKS, 32'sd1);
    send_item(MIN_TICKS + 64'sd20_000_000_000, 32'sd1);
    send_item(MAX_TICKS, 32'sd1);
    write_anchor(MIN_TICKS);
    send_item(64'sd0, 32'sd10);
    send_item(64'sd184467440738, 32'sd10);
    send_item(64'sd184467440737, 32'sd10);
    write_anchor(MAX_TICKS);
    send_item(-64'sd5, MAX_SCALE);
    send_item(-64'sd5, MAX_SCALE);
    send_item(64'sd2147483642, MAX_SCALE);
    send_item(-64'sd4, MAX_SCALE);
    write_anchor(64'sd1000);
    send_item(MAX_TICKS, MAX_SCALE);
    send_item(MAX_TICKS, MAX_SCALE);

    for (int ph = 0; ph < 14; ph++) begin
      wide = {$urandom, $urandom};
      case (ph)
        0: anchor_val = 64'sd0;
        1: anchor_val = MAX_TICKS;
        2: anchor_val = MIN_TICKS;
        default: anchor_val = $urandom_range(0, 1) ? wide : {{24{wide[39]}}, wide[39:0]};
      endcase
      write_anchor(anchor_val);
      quiet = (ph % 4 == 3);
      if (ph == 5) hold_off_req = 1'b1;

      case ($urandom_range(0, 7))
        0: scale = $urandom_range(1, 1000);
        1: scale = 32'sd1;
        2: scale = 32'sd48000;
        3: scale = 32'sd90000;
        4: scale = 32'sd1_000_000_000;
        5: scale = $urandom_range(1, 32'h7FFF_FFFF);
        default: scale = MAX_SCALE - $urandom_range(0, 1);
      endcase
      wide = {$urandom, $urandom};
      case ($urandom_range(0, 3))
        0: start = wide;
        1: start = MIN_TICKS + $urandom_range(0, 1000);
        2: start = MAX_TICKS - wide[31:0];
        default: start = {{32{wide[31]}}, wide[31:0]};
      endcase

      for (int n = 0; n < 52; n++) begin
        if (ph == 7 && n == 26) drain();
        base = sb.anchored ? sb.last_ticks : start;
        r = $urandom_range(0, 99);
        ts = scale;
        step = {$urandom, $urandom} % ({32'd0, scale} * 64'd8 + 64'd1);
        tick = base + step;
        if (r < 6) begin
          ts = (r == 0) ? 32'sd0 : ($urandom | 32'h8000_0000);
          tick = {$urandom, $urandom};
        end else if (r < 11) begin
          ts = (scale == MAX_SCALE) ? 32'sd1 : scale + 32'sd1;
        end else if (r < 16) begin
          tick = base - $urandom_range(1, 1000);
        end else if (r < 20) begin
          tick = base + ({$urandom, $urandom} >> $urandom_range(1, 40));
        end else if (r < 25) begin
          tick = base;
        end
        send_item(tick, ts);
      end
    end

    drain();
    repeat (150) @(negedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
